[rtl/hmt_pkg.sv]
// Package for the heartbeat membership table core.
// Holds table sizing, operation, result and register codes, and the entry record type.
package hmt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = 32 + 16 + 32 + 32;

    localparam logic [1:0] OP_MERGE     = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_LIST_ALL  = 2'd2;
    localparam logic [1:0] OP_LIST_LIVE = 2'd3;

    localparam logic [1:0] KIND_MERGE   = 2'd0;
    localparam logic [1:0] KIND_REMOVED = 2'd1;
    localparam logic [1:0] KIND_LISTED  = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [1:0] ST_UPDATED   = 2'd0;
    localparam logic [1:0] ST_UNCHANGED = 2'd1;
    localparam logic [1:0] ST_INSERTED  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] REG_SELF_ID      = 2'd0;
    localparam logic [1:0] REG_SELF_PORT    = 2'd1;
    localparam logic [1:0] REG_FAIL_LIMIT   = 2'd2;
    localparam logic [1:0] REG_REMOVE_LIMIT = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] heartbeat;
        logic [31:0] stamp;
    } entry_t;

endpackage

[rtl/hmt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module hmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/heartbeat_membership_table_core.sv]
// Top level of the heartbeat membership table core.
// Uses hmt_pkg and one hmt_ram instance for the entry table.
//
// An operation is taken when start is high and busy is low. Busy stays high
// while the table is walked, one entry per cycle through the single memory
// read port. A merge walk stops at the entry it matches, or reads every entry
// when it matches nothing; a list reads every entry. A tick runs a self
// merge walk and then a compaction walk over the possibly grown table, in
// which the write index falls one behind the read index per removal. Results
// appear on the result ports for exactly one cycle with result_valid high,
// one per cycle at most, and the receiver cannot stall them. A scanned result
// is held until the next one arrives or the walk ends, so the final one can
// carry last. The final result shows in the cycle in which busy falls,
// and a new operation can be taken in that same cycle. The table needs no
// clearing pass: only entries below the entry count are ever read.
module heartbeat_membership_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] node_id,
    input  logic [15:0] node_port,
    input  logic [31:0] entry_heartbeat,
    input  logic [31:0] now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [31:0] result_id,
    output logic [15:0] result_port,
    output logic [31:0] result_heartbeat,
    output logic [31:0] result_time,
    output logic [1:0]  merge_status,
    output logic        last
);
    import hmt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MREAD = 6'b000010, // merge search: compare the entry that arrives
        S_MEND  = 6'b000100, // merge search finished without a match
        S_DONE  = 6'b001000, // merge finished: report, or go on to compact
        S_SCAN  = 6'b010000, // compaction or listing walk
        S_FLUSH = 6'b100000  // final result of a walk, or nothing to report
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] self_id_reg;
    logic [15:0] self_port_reg, fail_limit_reg, remove_limit_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] own_hb_reg, own_hb_next;

    // Latched operation.
    logic [1:0]  op_reg, op_next;
    logic [31:0] id_reg, id_next, hb_reg, hb_next, now_reg, now_next;
    logic [15:0] port_reg, port_next;
    logic [1:0]  st_reg, st_next;       // status of the merge in progress

    // Walk pointers: rd is the entry whose data arrives this cycle.
    logic [CNT_W-1:0] rd_reg, rd_next, wr_reg, wr_next;

    // RAM.
    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           wdata, rdata;

    // Held scan result, shown once the next one arrives or the walk ends.
    logic        hold_v_reg, hold_v_next;
    logic [1:0]  hold_k_reg, hold_k_next;
    entry_t      hold_e_reg, hold_e_next;

    // Result register.
    logic        rv_reg, rv_next, last_reg, last_next;
    logic [1:0]  kind_reg, kind_next, mst_reg, mst_next;
    entry_t      res_reg, res_next;

    logic [31:0] age;
    logic        key_hit, walk_more, emit;

    hmt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg      <= '0;
            self_port_reg    <= '0;
            fail_limit_reg   <= 16'd5;
            remove_limit_reg <= 16'd20;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SELF_ID:      self_id_reg      <= cfg_data;
                REG_SELF_PORT:    self_port_reg    <= cfg_data[15:0];
                REG_FAIL_LIMIT:   fail_limit_reg   <= cfg_data[15:0];
                REG_REMOVE_LIMIT: remove_limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        own_hb_next = own_hb_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        port_next   = port_reg;
        hb_next     = hb_reg;
        now_next    = now_reg;
        st_next     = st_reg;
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        hold_v_next = hold_v_reg;
        hold_k_next = hold_k_reg;
        hold_e_next = hold_e_reg;
        rv_next     = 1'b0;
        last_next   = 1'b0;
        kind_next   = kind_reg;
        mst_next    = mst_reg;
        res_next    = res_reg;
        we          = 1'b0;
        waddr       = wr_reg[IDX_W-1:0];
        wdata       = rdata;
        raddr       = rd_reg[IDX_W-1:0];
        age         = now_reg - rdata.stamp;
        key_hit     = (rdata.id == id_reg) && (rdata.port == port_reg);
        walk_more   = (rd_reg + 1'b1) < count_reg;
        emit        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                if (start)
                begin
                    op_next     = operation;
                    now_next    = now;
                    rd_next     = '0;
                    wr_next     = '0;
                    hold_v_next = 1'b0;
                    if (operation == OP_TICK)
                    begin
                        own_hb_next = (own_hb_reg == 32'hFFFF_FFFF) ? own_hb_reg
                                                                    : own_hb_reg + 1'b1;
                        id_next   = self_id_reg;
                        port_next = self_port_reg;
                        hb_next   = own_hb_next;
                    end
                    else
                    begin
                        id_next   = node_id;
                        port_next = node_port;
                        hb_next   = entry_heartbeat;
                    end
                    if (operation == OP_MERGE || operation == OP_TICK)
                    begin
                        state_next = (count_reg != '0) ? S_MREAD : S_MEND;
                    end
                    else
                    begin
                        state_next = (count_reg != '0) ? S_SCAN : S_FLUSH;
                    end
                end
            end

            S_MREAD:
            begin
                if (key_hit)
                begin
                    st_next = ST_UNCHANGED;
                    if (hb_reg > rdata.heartbeat)
                    begin
                        st_next         = ST_UPDATED;
                        we              = 1'b1;
                        waddr           = rd_reg[IDX_W-1:0];
                        wdata.heartbeat = hb_reg;
                        wdata.stamp     = now_reg;
                    end
                    state_next = S_DONE;
                end
                else if (walk_more)
                begin
                    rd_next = rd_reg + 1'b1;
                    raddr   = rd_next[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_MEND;
                end
            end

            S_MEND:
            begin
                if (count_reg >= CNT_W'(TABLE_DEPTH))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    st_next    = ST_INSERTED;
                    we         = 1'b1;
                    waddr      = count_reg[IDX_W-1:0];
                    wdata      = '{id: id_reg, port: port_reg,
                                   heartbeat: hb_reg, stamp: now_reg};
                    count_next = count_reg + 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // A merge reports its status; a tick drops it and compacts.
                if (op_reg == OP_MERGE)
                begin
                    rv_next    = 1'b1;
                    last_next  = 1'b1;
                    kind_next  = KIND_MERGE;
                    mst_next   = st_reg;
                    res_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_next    = '0;
                    wr_next    = '0;
                    raddr      = '0;
                    state_next = (count_reg != '0) ? S_SCAN : S_FLUSH;
                end
            end

            S_SCAN:
            begin
                // One entry per cycle; rdata holds entry rd_reg. Kept entries of
                // a tick move down to the write index.
                if (op_reg == OP_TICK)
                begin
                    if (age > 32'(remove_limit_reg))
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        we      = (wr_reg != rd_reg);
                        waddr   = wr_reg[IDX_W-1:0];
                        wdata   = rdata;
                        wr_next = wr_reg + 1'b1;
                    end
                end
                else if (op_reg == OP_LIST_ALL || age <= 32'(fail_limit_reg))
                begin
                    emit = 1'b1;
                end
                if (emit)
                begin
                    // A newer result exists, so the held one is not the last.
                    if (hold_v_reg)
                    begin
                        rv_next   = 1'b1;
                        kind_next = hold_k_reg;
                        mst_next  = ST_UPDATED;
                        res_next  = hold_e_reg;
                    end
                    hold_v_next = 1'b1;
                    hold_k_next = (op_reg == OP_TICK) ? KIND_REMOVED : KIND_LISTED;
                    hold_e_next = rdata;
                end
                if (walk_more)
                begin
                    rd_next = rd_reg + 1'b1;
                    raddr   = rd_next[IDX_W-1:0];
                end
                else
                begin
                    if (op_reg == OP_TICK)
                    begin
                        count_next = wr_next;
                    end
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                // The held result closes the walk; without one, report nothing.
                rv_next   = 1'b1;
                last_next = 1'b1;
                mst_next  = ST_UPDATED;
                if (hold_v_reg)
                begin
                    kind_next = hold_k_reg;
                    res_next  = hold_e_reg;
                end
                else
                begin
                    kind_next = KIND_NONE;
                    res_next  = '0;
                end
                hold_v_next = 1'b0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            own_hb_reg <= '0;
            hold_v_reg <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            own_hb_reg <= own_hb_next;
            hold_v_reg <= hold_v_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        port_reg   <= port_next;
        hb_reg     <= hb_next;
        now_reg    <= now_next;
        st_reg     <= st_next;
        rd_reg     <= rd_next;
        wr_reg     <= wr_next;
        hold_k_reg <= hold_k_next;
        hold_e_reg <= hold_e_next;
        kind_reg   <= kind_next;
        mst_reg    <= mst_next;
        res_reg    <= res_next;
        last_reg   <= last_next;
    end

    assign result_valid     = rv_reg;
    assign result_kind      = kind_reg;
    assign merge_status     = mst_reg;
    assign result_id        = res_reg.id;
    assign result_port      = res_reg.port;
    assign result_heartbeat = res_reg.heartbeat;
    assign result_time      = res_reg.stamp;
    assign last             = last_reg;
endmodule

[rtl/hmt_checker.sv]
// Port-level checker for the heartbeat membership table core.
// Uses hmt_pkg codes; bound to the top level below.
module hmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [1:0]  result_kind,
    input logic [1:0]  merge_status,
    input logic [31:0] result_id,
    input logic        last
);
    import hmt_pkg::*;

    // A merge status result always closes its operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_MERGE |-> last)
        else $error("merge result without last");

    // A nothing-to-report result carries a cleared id and closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_NONE |-> last && result_id == '0)
        else $error("empty marker malformed");

    // Entry results carry a zero merge status.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind != KIND_MERGE |-> merge_status == ST_UPDATED)
        else $error("status on entry result");

    // An accepted operation makes the block busy next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accept without busy");
endmodule

bind heartbeat_membership_table_core hmt_checker u_hmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .merge_status (merge_status),
    .result_id    (result_id),
    .last         (last)
);

[tb/heartbeat_membership_table_core_tb.sv]
// Self-checking testbench for heartbeat_membership_table_core.
// Depends on hmt_pkg and the core; predicts each operation's results in a local
// copy of the member table and compares every result transfer field by field.
`timescale 1ns / 100ps

module heartbeat_membership_table_core_tb;
    import hmt_pkg::*;

    // One operation as presented on the command ports.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] tnow;
    } command_t;

    // One result as seen on the result ports.
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] stamp;
        logic [1:0]  status;
        logic        fin;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = OP_MERGE;
    logic [31:0] node_id = '0;
    logic [15:0] node_port = '0;
    logic [31:0] entry_heartbeat = '0;
    logic [31:0] now = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SELF_ID;
    logic [31:0] cfg_data = '0;
    logic        result_valid;
    logic [1:0]  result_kind;
    logic [31:0] result_id;
    logic [15:0] result_port;
    logic [31:0] result_heartbeat;
    logic [31:0] result_time;
    logic [1:0]  merge_status;
    logic        last;

    heartbeat_membership_table_core DUT (.*);

    always #1 clk = ~clk;

    // Predictor state: configuration and the member table.
    logic [31:0] my_id = '0;
    logic [15:0] my_port = '0;
    logic [15:0] live_age = 16'd5;
    logic [15:0] drop_age = 16'd20;
    entry_t      members[TABLE_DEPTH];
    int          member_count = 0;
    logic [31:0] my_beat = '0;

    command_t pending_cmds[$];
    report_t  awaited_reports[$];
    int       errors = 0;
    int       in_flight = 0;   // commands queued plus the one on the ports
    int       gap_left = 0;
    int       burst_left = 0;

    function automatic report_t mk(logic [1:0] k, entry_t e, logic [1:0] s);
        report_t r;
        r.kind = k; r.id = e.id; r.port = e.port; r.hb = e.heartbeat;
        r.stamp = e.stamp; r.status = s; r.fin = 1'b0;
        return r;
    endfunction

    function automatic logic [1:0] merge_member(logic [31:0] id, logic [15:0] port,
                                                logic [31:0] hb, logic [31:0] tnow);
        for (int i = 0; i < member_count; i++) begin
            if (members[i].id == id && members[i].port == port) begin
                if (hb > members[i].heartbeat) begin
                    members[i].heartbeat = hb;
                    members[i].stamp = tnow;
                    return ST_UPDATED;
                end
                return ST_UNCHANGED;
            end
        end
        if (member_count >= TABLE_DEPTH) return ST_FULL;
        members[member_count] = '{id, port, hb, tnow};
        member_count++;
        return ST_INSERTED;
    endfunction

    // Works out the results of one accepted command and queues them.
    task automatic predict_membership(command_t c);
        report_t got[$];
        entry_t  zero;
        logic [1:0] st;
        int i;
        zero = '0;
        if (c.op == OP_MERGE) begin
            st = merge_member(c.id, c.port, c.hb, c.tnow);
            got.insert(got.size(), mk(KIND_MERGE, zero, st));
        end else if (c.op == OP_TICK) begin
            if (my_beat != 32'hFFFF_FFFF) my_beat++;
            void'(merge_member(my_id, my_port, my_beat, c.tnow));
            i = 0;
            while (i < member_count) begin
                if (32'(c.tnow - members[i].stamp) > {16'd0, drop_age}) begin
                    got.insert(got.size(), mk(KIND_REMOVED, members[i], ST_UPDATED));
                    for (int j = i; j + 1 < member_count; j++) members[j] = members[j + 1];
                    member_count--;
                end else begin
                    i++;
                end
            end
        end else begin
            for (i = 0; i < member_count; i++) begin
                if (c.op == OP_LIST_LIVE &&
                    32'(c.tnow - members[i].stamp) > {16'd0, live_age}) continue;
                got.insert(got.size(), mk(KIND_LISTED, members[i], ST_UPDATED));
            end
        end
        if (got.size() == 0) got.insert(0, mk(KIND_NONE, zero, ST_UPDATED));
        got[got.size() - 1].fin = 1'b1;
        foreach (got[k]) awaited_reports.insert(awaited_reports.size(), got[k]);
    endtask

    // Driver: takes commands from the queue in bursts separated by random gaps.
    // A command is transferred at an edge where start is high and busy is low.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                predict_membership('{operation, node_id, node_port, entry_heartbeat, now});
                in_flight--;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    command_t c;
                    c = pending_cmds.pop_front();
                    operation <= c.op; node_id <= c.id; node_port <= c.port;
                    entry_heartbeat <= c.hb; now <= c.tnow;
                    start <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result strobe is a transfer and is checked against the
    // oldest expectation.
    always @(posedge clk) begin
        if (rst_n && result_valid) begin
            if (awaited_reports.size() == 0) begin
                $error("unexpected result kind %0d", result_kind);
                errors++;
            end else begin
                report_t e;
                e = awaited_reports.pop_front();
                if (result_kind !== e.kind) begin
                    $error("result_kind exp %0d got %0d", e.kind, result_kind); errors++;
                end
                if (result_id !== e.id) begin
                    $error("result_id exp %h got %h", e.id, result_id); errors++;
                end
                if (result_port !== e.port) begin
                    $error("result_port exp %h got %h", e.port, result_port); errors++;
                end
                if (result_heartbeat !== e.hb) begin
                    $error("result_heartbeat exp %h got %h", e.hb, result_heartbeat);
                    errors++;
                end
                if (result_time !== e.stamp) begin
                    $error("result_time exp %h got %h", e.stamp, result_time); errors++;
                end
                if (merge_status !== e.status) begin
                    $error("merge_status exp %0d got %0d", e.status, merge_status); errors++;
                end
                if (last !== e.fin) begin
                    $error("last exp %0b got %0b", e.fin, last); errors++;
                end
            end
        end
    end

    // Writes one register through the configuration channel and updates the
    // predictor's copy. Only called while the core is idle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SELF_ID:      my_id = val;
            REG_SELF_PORT:    my_port = val[15:0];
            REG_FAIL_LIMIT:   live_age = val[15:0];
            REG_REMOVE_LIMIT: drop_age = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send(logic [1:0] op, logic [31:0] id, logic [15:0] port,
                        logic [31:0] hb, logic [31:0] tnow);
        pending_cmds.insert(pending_cmds.size(), '{op, id, port, hb, tnow});
        in_flight++;
    endtask

    // Waits until every command is transferred and every result has come,
    // then lets a tick's worth of cycles pass so the core is surely idle.
    task automatic drain();
        while (in_flight > 0 || awaited_reports.size() > 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    logic [31:0] clock_now = 32'd1000;

    // One random phase. Most traffic is merges, many on a small pool of keys, with
    // time advancing at random, so entries age, get refreshed, fill and drain.
    task automatic random_phase(int count);
        logic [31:0] pool_id[8];
        logic [15:0] pool_port[8];
        int k;
        for (int p = 0; p < 8; p++) begin
            pool_id[p] = $urandom;
            pool_port[p] = 16'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) clock_now += $urandom_range(0, 12);
            if (k < 45) begin
                int p;
                p = $urandom_range(0, 7);
                send(OP_MERGE, pool_id[p], pool_port[p], $urandom_range(0, 40),
                     clock_now - $urandom_range(0, 3));
            end else if (k < 60) begin
                send(OP_MERGE, $urandom, 16'($urandom), $urandom, clock_now);
            end else if (k < 78) begin
                send(OP_TICK, $urandom, 16'($urandom), $urandom, clock_now);
            end else if (k < 88) begin
                send(OP_LIST_ALL, $urandom, 16'($urandom), $urandom, clock_now);
            end else if (k < 96) begin
                send(OP_LIST_LIVE, $urandom, 16'($urandom), $urandom, clock_now);
            end else begin
                // Time jumps far ahead or wraps backward.
                send(2'($urandom_range(0, 3)), $urandom, 16'($urandom), $urandom,
                     $urandom);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with reset configuration: empty-table lists, field extremes,
        // insert, update, equal heartbeat, live filtering and ticks.
        send(OP_LIST_ALL, '0, '0, '0, '0);
        send(OP_LIST_LIVE, '0, '0, '0, '0);
        send(OP_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd7);
        send(OP_MERGE, '0, '0, '0, '0);
        send(OP_MERGE, '0, '0, 32'd1, 32'd3);
        send(OP_MERGE, '0, 16'd1, 32'd5, 32'd3);
        send(OP_LIST_LIVE, '0, '0, '0, 32'd8);
        send(OP_LIST_ALL, '0, '0, '0, 32'd8);
        send(OP_TICK, '0, '0, '0, 32'd10);
        send(OP_TICK, '0, '0, '0, 32'd40);
        send(OP_LIST_ALL, '0, '0, '0, 32'd40);
        drain();

        // Fill the table, then overflow it, then let a tick with no self room.
        write_reg(REG_SELF_ID, 32'hDEAD_BEEF);
        write_reg(REG_SELF_PORT, 32'h0000_FFFF);
        write_reg(REG_FAIL_LIMIT, 32'd0);
        write_reg(REG_REMOVE_LIMIT, 32'd65535);
        for (int i = 0; i < TABLE_DEPTH + 2; i++) send(OP_MERGE, i, 16'(i), i, 32'd100 + i);
        send(OP_TICK, '0, '0, '0, 32'd140);
        send(OP_LIST_LIVE, '0, '0, '0, 32'd133);
        send(OP_TICK, '0, '0, '0, 32'd200000);
        drain();

        // Top heartbeat: own entry at the top heartbeat stays unchanged through a tick.
        write_reg(REG_REMOVE_LIMIT, 32'd0);
        write_reg(REG_FAIL_LIMIT, 32'd65535);
        send(OP_MERGE, 32'hDEAD_BEEF, 16'hFFFF, 32'hFFFF_FFFF, 32'd5);
        send(OP_TICK, '0, '0, '0, 32'd5);
        send(OP_LIST_ALL, '0, '0, '0, 32'd5);
        drain();

        // Random phases under a few settings, extremes among them.
        write_reg(REG_FAIL_LIMIT, 32'd5);
        write_reg(REG_REMOVE_LIMIT, 32'd20);
        random_phase(140);
        drain();
        write_reg(REG_SELF_ID, $urandom);
        write_reg(REG_SELF_PORT, $urandom);
        write_reg(REG_FAIL_LIMIT, 32'd2);
        write_reg(REG_REMOVE_LIMIT, 32'd60);
        random_phase(140);
        drain();
        write_reg(REG_FAIL_LIMIT, 32'd65535);
        write_reg(REG_REMOVE_LIMIT, 32'd8);
        random_phase(100);
        drain();

        if (errors == 0 && awaited_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
